// ===== rtl/core/fpa_pkg.sv =====
// shared types and constants for the fixed block pool allocator
package fpa_pkg;

  // fixed field widths
  localparam int OFF_W     = 20;
  localparam int CNT_W     = 9;
  localparam int BB_W      = 13;
  localparam int CFG_W     = 13;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int DIV_CNT_W = $clog2(CNT_W);

  // smallest block the pool hands out
  localparam int unsigned MIN_BLOCK_BYTES = 8;

  // configuration reset values
  localparam logic [BB_W-1:0]  BLOCK_BYTES_RST   = BB_W'(8);
  localparam logic [CNT_W-1:0] BLOCKS_IN_USE_RST = CNT_W'(256);

  // register indexes on the configuration channel
  localparam logic REG_BLOCK_BYTES   = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_BLOCK   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_OFFSET = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              load_in;
    logic              alloc_read;
    logic              mul_limit;
    logic              alloc_commit;
    logic              div_start;
    logic              div_step;
    logic              free_commit;
    logic              init_latch;
    logic              walk_step;
    logic              init_commit;
    logic              init_empty;
    logic              respond;
    logic [STAT_W-1:0] resp_status;
    logic              resp_offset;
  } fpa_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic alloc_empty;
    logic range_bad;
    logic div_last;
    logic rem_zero;
    logic walk_last;
    logic count_zero;
  } fpa_flags_t;

endpackage

// ===== rtl/core/fpa_ctrl.sv =====
// controller state machine for the fixed block pool allocator
module fpa_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [fpa_pkg::OP_W-1:0] op,
  output logic                     busy,
  output fpa_pkg::fpa_cmd_t        cmd,
  input  fpa_pkg::fpa_flags_t      flags
);
  import fpa_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ALLOC_WB = 3'd1;
  localparam logic [2:0] S_CHECK    = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_FREE_WB  = 3'd4;
  localparam logic [2:0] S_WALK     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_ALLOC: begin
              if (flags.alloc_empty) begin
                cmd.respond     = 1'b1;
                cmd.resp_status = ST_NO_BLOCK;
              end else begin
                cmd.alloc_read = 1'b1;
                state_next     = S_ALLOC_WB;
              end
            end
            OP_FREE: begin
              cmd.load_in   = 1'b1;
              cmd.mul_limit = 1'b1;
              state_next    = S_CHECK;
            end
            OP_INIT: begin
              cmd.init_latch = 1'b1;
              if (flags.count_zero) begin
                cmd.init_empty  = 1'b1;
                cmd.respond     = 1'b1;
                cmd.resp_status = ST_NO_BLOCK;
              end else begin
                state_next = S_WALK;
              end
            end
            default: begin
              cmd.respond     = 1'b1;
              cmd.resp_status = ST_OK;
            end
          endcase
        end
      end
      S_ALLOC_WB: begin
        cmd.alloc_commit = 1'b1;
        cmd.respond      = 1'b1;
        cmd.resp_status  = ST_OK;
        cmd.resp_offset  = 1'b1;
        state_next       = S_IDLE;
      end
      S_CHECK: begin
        if (flags.range_bad) begin
          cmd.respond     = 1'b1;
          cmd.resp_status = ST_BAD_OFFSET;
          state_next      = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (flags.div_last) begin
          state_next = S_FREE_WB;
        end
      end
      S_FREE_WB: begin
        cmd.respond = 1'b1;
        if (flags.rem_zero) begin
          cmd.free_commit = 1'b1;
          cmd.resp_status = ST_OK;
        end else begin
          cmd.resp_status = ST_BAD_OFFSET;
        end
        state_next = S_IDLE;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (flags.walk_last) begin
          cmd.init_commit = 1'b1;
          cmd.respond     = 1'b1;
          cmd.resp_status = ST_OK;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/fpa_dpath.sv =====
// datapath for the fixed block pool allocator: link memory, multiplier, divider
module fpa_dpath #(
  parameter int NUM_BLOCKS      = 256,
  parameter int MAX_BLOCK_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fpa_pkg::fpa_cmd_t           cmd,
  output fpa_pkg::fpa_flags_t         flags,
  input  logic [fpa_pkg::OFF_W-1:0]   byte_offset,
  input  logic [fpa_pkg::BB_W-1:0]    block_bytes,
  input  logic [fpa_pkg::CNT_W-1:0]   blocks_in_use,
  output logic                        done,
  output logic [fpa_pkg::STAT_W-1:0]  status,
  output logic [fpa_pkg::OFF_W-1:0]   block_offset,
  output logic [fpa_pkg::CNT_W-1:0]   free_blocks
);
  import fpa_pkg::*;

  localparam int ADDR_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LINK_W  = $clog2(NUM_BLOCKS + 1);
  localparam int SIZE_W  = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int MUL_A_W = (CNT_W > LINK_W) ? CNT_W : LINK_W;
  localparam int PROD_W  = MUL_A_W + SIZE_W;
  localparam int DIV_W   = (OFF_W > SIZE_W + CNT_W) ? OFF_W : SIZE_W + CNT_W;
  localparam int CMP_W   = (PROD_W > OFF_W) ? PROD_W : OFF_W;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_BLOCKS);

  // link memory, undefined until init writes it
  logic [LINK_W-1:0] next_link [NUM_BLOCKS];
  logic [LINK_W-1:0] rd_data;

  logic [LINK_W-1:0]    head;
  logic [CNT_W-1:0]     free_total;
  logic                 pool_ready;
  logic [SIZE_W-1:0]    held_size;
  logic [CNT_W-1:0]     held_count;
  logic [OFF_W-1:0]     offs;
  logic [PROD_W-1:0]    prod;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvs;
  logic [CNT_W-1:0]     quot;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W-1:0]     walk_idx;

  logic [SIZE_W-1:0]  size_clamp;
  logic [CNT_W-1:0]   count_clamp;
  logic [MUL_A_W-1:0] mul_a;
  logic [CNT_W-1:0]   walk_nxt;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [LINK_W-1:0]  wr_data;

  // clamp the configured size and count
  always_comb begin
    if (block_bytes < BB_W'(MIN_BLOCK_BYTES)) begin
      size_clamp = SIZE_W'(MIN_BLOCK_BYTES);
    end else if (32'(block_bytes) > MAX_BLOCK_BYTES) begin
      size_clamp = SIZE_W'(MAX_BLOCK_BYTES);
    end else begin
      size_clamp = SIZE_W'(block_bytes);
    end
    if (32'(blocks_in_use) > NUM_BLOCKS) begin
      count_clamp = CNT_W'(NUM_BLOCKS);
    end else begin
      count_clamp = blocks_in_use;
    end
  end

  // status toward the controller
  assign walk_nxt          = walk_idx + CNT_W'(1);
  assign flags.alloc_empty = !pool_ready || (head == LINK_NULL) || (free_total == '0);
  assign flags.range_bad   = !pool_ready || (CMP_W'(offs) >= CMP_W'(prod));
  assign flags.div_last    = (div_cnt == '0);
  assign flags.rem_zero    = (rem == '0);
  assign flags.walk_last   = (walk_nxt == held_count);
  assign flags.count_zero  = (count_clamp == '0);

  // link memory write selection: init walk or free push
  always_comb begin
    wr_en   = cmd.walk_step || cmd.free_commit;
    wr_addr = ADDR_W'(walk_idx);
    wr_data = flags.walk_last ? LINK_NULL : LINK_W'(walk_nxt);
    if (cmd.free_commit) begin
      wr_addr = ADDR_W'(quot);
      wr_data = head;
    end
  end

  // link memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      next_link[wr_addr] <= wr_data;
    end
    if (cmd.alloc_read) begin
      rd_data <= next_link[head[ADDR_W-1:0]];
    end
  end

  // shared multiplier: block index times size, or count times size
  assign mul_a = cmd.mul_limit ? MUL_A_W'(held_count) : MUL_A_W'(head);

  always_ff @(posedge clk) begin
    if (cmd.alloc_read || cmd.mul_limit) begin
      prod <= PROD_W'(mul_a) * PROD_W'(held_size);
    end
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      offs <= byte_offset;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= DIV_W'(offs);
      dvs     <= DIV_W'(held_size) << (CNT_W - 1);
      quot    <= '0;
      div_cnt <= DIV_CNT_W'(CNT_W - 1);
    end else if (cmd.div_step) begin
      if (rem >= dvs) begin
        rem  <= rem - dvs;
        quot <= {quot[CNT_W-2:0], 1'b1};
      end else begin
        quot <= {quot[CNT_W-2:0], 1'b0};
      end
      dvs     <= dvs >> 1;
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // init walk index
  always_ff @(posedge clk) begin
    if (cmd.init_latch) begin
      walk_idx <= '0;
    end else if (cmd.walk_step) begin
      walk_idx <= walk_nxt;
    end
  end

  // pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= LINK_NULL;
      free_total <= '0;
      pool_ready <= 1'b0;
      held_size  <= SIZE_W'(MIN_BLOCK_BYTES);
      held_count <= '0;
    end else begin
      if (cmd.init_latch) begin
        held_size  <= size_clamp;
        held_count <= count_clamp;
      end
      if (cmd.init_empty) begin
        head       <= LINK_NULL;
        free_total <= '0;
        pool_ready <= 1'b0;
      end else if (cmd.init_commit) begin
        head       <= '0;
        free_total <= held_count;
        pool_ready <= 1'b1;
      end else if (cmd.alloc_commit) begin
        head       <= rd_data;
        free_total <= free_total - CNT_W'(1);
      end else if (cmd.free_commit) begin
        head <= LINK_W'(quot);
        if (free_total < held_count) begin
          free_total <= free_total + CNT_W'(1);
        end
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      status       <= cmd.resp_status;
      block_offset <= cmd.resp_offset ? OFF_W'(prod) : '0;
    end
  end

  assign free_blocks = free_total;

`ifndef SYNTHESIS
  // the new count is latched before the walk, the free count only at its end
  a_free_le_count: assert property (@(posedge clk) disable iff (rst)
    !cmd.walk_step |-> (free_total <= held_count))
    else $error("free count above pool size");

  a_not_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !pool_ready |-> (free_total == '0) && (head == LINK_NULL))
    else $error("pool not ready but list not empty");

  a_alloc_has_block: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_commit |-> (free_total != '0) && (head != LINK_NULL))
    else $error("allocation from an empty list");

  a_free_idx_range: assert property (@(posedge clk) disable iff (rst)
    cmd.free_commit |-> (quot < held_count))
    else $error("freed block index outside the pool");
`endif

endmodule

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// top level of the fixed block pool allocator: config registers, controller, datapath
//
// Usage:
//   Command channel: drive op and byte_offset with start high; the item is
//   taken at a rising edge where start is high and busy is low. op 0 pops a
//   block and returns its byte offset, op 1 frees the block at byte_offset,
//   op 2 rebuilds the free list from the configuration registers.
//   Results: done is high for exactly one cycle with status, block_offset and
//   free_blocks; the receiver cannot stall, so the result must be taken then.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 block size,
//   1 block count) and cfg_data; cfg_ready is always high. Values are used
//   only at the next init, so write them while the block is idle.
//   Steps from accept to done: op 3, an empty alloc or an init of zero
//   blocks are answered from idle; alloc does a link memory read plus the
//   index times size multiply; a free does the limit multiply and range
//   check, then, if in range, a 9-step restoring divide and, if aligned, a
//   link write; init does one link memory write per block.
//   One item is in flight at a time; busy stays high until its result.
//   Reset: the pool is empty and not ready until an init; size 8, count 256.
module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS      = 256,
  parameter int MAX_BLOCK_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [fpa_pkg::OP_W-1:0]     op,
  input  logic [fpa_pkg::OFF_W-1:0]    byte_offset,
  output logic                         done,
  output logic [fpa_pkg::STAT_W-1:0]   status,
  output logic [fpa_pkg::OFF_W-1:0]    block_offset,
  output logic [fpa_pkg::CNT_W-1:0]    free_blocks,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [fpa_pkg::CFG_W-1:0]    cfg_data
);
  import fpa_pkg::*;

  logic [BB_W-1:0]  block_bytes;
  logic [CNT_W-1:0] blocks_in_use;
  fpa_cmd_t         cmd;
  fpa_flags_t       flags;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes   <= BLOCK_BYTES_RST;
      blocks_in_use <= BLOCKS_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLOCK_BYTES:   block_bytes   <= cfg_data[BB_W-1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencing
  fpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .busy  (busy),
    .cmd   (cmd),
    .flags (flags)
  );

  // storage and arithmetic
  fpa_dpath #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .flags         (flags),
    .byte_offset   (byte_offset),
    .block_bytes   (block_bytes),
    .blocks_in_use (blocks_in_use),
    .done          (done),
    .status        (status),
    .block_offset  (block_offset),
    .free_blocks   (free_blocks)
  );

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the fixed block pool allocator
`timescale 1ns / 1ps

module tb_top;
  import fpa_pkg::*;

  localparam int POOL_BLOCKS    = 256;
  localparam int POOL_MAX_BYTES = 4096;
  localparam int LINK_AW        = $clog2(POOL_BLOCKS);
  localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [CNT_W-1:0] LINK_NULL = CNT_W'(POOL_BLOCKS);
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 260;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 88;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  free_blocks;
  } pool_resp_t;

  typedef struct packed {
    logic             is_cfg;
    logic [OP_W-1:0]  op;
    logic             cfg_idx;
    logic [OFF_W-1:0] data;
    logic             typed;
    pool_resp_t       resp;
  } plan_row_t;

  // directed opening: pre-init, extremes, bad offsets, double free, empty pool
  localparam plan_row_t PLAN [30] = '{
    '{1'b0, OP_ALLOC,  1'b0, 20'h00000, 1'b1, '{ST_NO_BLOCK,   20'h0, 9'd0}},
    '{1'b0, OP_FREE,   1'b0, 20'h00000, 1'b1, '{ST_BAD_OFFSET, 20'h0, 9'd0}},
    '{1'b0, OP_UNUSED, 1'b0, 20'h00000, 1'b1, '{ST_OK,         20'h0, 9'd0}},
    '{1'b0, OP_INIT,   1'b0, 20'hABCDE, 1'b1, '{ST_OK,         20'h0, 9'd256}},
    '{1'b0, OP_ALLOC,  1'b0, 20'h00000, 1'b1, '{ST_OK,         20'h0, 9'd255}},
    '{1'b0, OP_ALLOC,  1'b0, 20'h00000, 1'b1, '{ST_OK,         20'h8, 9'd254}},
    '{1'b0, OP_FREE,   1'b0, 20'h00004, 1'b1, '{ST_BAD_OFFSET, 20'h0, 9'd254}},
    '{1'b0, OP_FREE,   1'b0, 20'h00800, 1'b1, '{ST_BAD_OFFSET, 20'h0, 9'd254}},
    '{1'b0, OP_FREE,   1'b0, 20'h00008, 1'b1, '{ST_OK,         20'h0, 9'd255}},
    '{1'b0, OP_FREE,   1'b0, 20'h00008, 1'b1, '{ST_OK,         20'h0, 9'd256}},
    '{1'b0, OP_FREE,   1'b0, 20'h00000, 1'b1, '{ST_OK,         20'h0, 9'd256}},
    '{1'b0, OP_ALLOC,  1'b0, 20'h00000, 1'b0, '0},
    '{1'b0, OP_UNUSED, 1'b0, 20'hFFFFF, 1'b0, '0},
    '{1'b1, OP_ALLOC,  REG_BLOCK_BYTES,   20'h01FFF, 1'b0, '0},
    '{1'b1, OP_ALLOC,  REG_BLOCKS_IN_USE, 20'h01FFF, 1'b0, '0},
    '{1'b0, OP_INIT,   1'b0, 20'h00000, 1'b1, '{ST_OK,         20'h0, 9'd256}},
    '{1'b0, OP_FREE,   1'b0, 20'hFF000, 1'b1, '{ST_OK,         20'h0, 9'd256}},
    '{1'b0, OP_ALLOC,  1'b0, 20'h00000, 1'b1, '{ST_OK,     20'hFF000, 9'd255}},
    '{1'b1, OP_ALLOC,  REG_BLOCKS_IN_USE, 20'h00000, 1'b0, '0},
    '{1'b0, OP_INIT,   1'b0, 20'h00000, 1'b1, '{ST_NO_BLOCK,   20'h0, 9'd0}},
    '{1'b0, OP_ALLOC,  1'b0, 20'h00000, 1'b1, '{ST_NO_BLOCK,   20'h0, 9'd0}},
    '{1'b0, OP_FREE,   1'b0, 20'h00000, 1'b1, '{ST_BAD_OFFSET, 20'h0, 9'd0}},
    '{1'b1, OP_ALLOC,  REG_BLOCK_BYTES,   20'h00001, 1'b0, '0},
    '{1'b1, OP_ALLOC,  REG_BLOCKS_IN_USE, 20'h00001, 1'b0, '0},
    '{1'b0, OP_INIT,   1'b0, 20'h00000, 1'b1, '{ST_OK,         20'h0, 9'd1}},
    '{1'b0, OP_ALLOC,  1'b0, 20'h00000, 1'b1, '{ST_OK,         20'h0, 9'd0}},
    '{1'b0, OP_ALLOC,  1'b0, 20'h00000, 1'b1, '{ST_NO_BLOCK,   20'h0, 9'd0}},
    '{1'b0, OP_FREE,   1'b0, 20'h00008, 1'b1, '{ST_BAD_OFFSET, 20'h0, 9'd0}},
    '{1'b0, OP_FREE,   1'b0, 20'h00000, 1'b1, '{ST_OK,         20'h0, 9'd1}},
    '{1'b0, OP_FREE,   1'b0, 20'hFFFFF, 1'b1, '{ST_BAD_OFFSET, 20'h0, 9'd1}}
  };

  // fixed register settings for the first random phases
  localparam logic [BB_W-1:0]  PHASE_BYTES  [6] = '{13'd8, 13'd4096, 13'd0,
                                                    13'd8191, 13'd13, 13'd4095};
  localparam logic [CFG_W-1:0] PHASE_COUNTS [6] = '{13'd256, 13'd256, 13'd1,
                                                    13'd2, 13'd511, 13'd255};
  localparam int PHASE_IDLE [3] = '{0, 77, 7};

  logic               clk;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    op          = OP_ALLOC;
  logic [OFF_W-1:0]   byte_offset = '0;
  logic               done;
  logic [STAT_W-1:0]  status;
  logic [OFF_W-1:0]   block_offset;
  logic [CNT_W-1:0]   free_blocks;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic               cfg_index   = REG_BLOCK_BYTES;
  logic [CFG_W-1:0]   cfg_data    = '0;

  // register shadows, sampled by the pool only at init
  logic [BB_W-1:0]    cfg_bytes   = BLOCK_BYTES_RST;
  logic [CNT_W-1:0]   cfg_blocks  = BLOCKS_IN_USE_RST;

  // free list mirror
  logic [CNT_W-1:0]   link_mem [POOL_BLOCKS];
  logic [CNT_W-1:0]   top_idx     = LINK_NULL;
  logic [CNT_W-1:0]   avail_cnt   = '0;
  logic               pool_live   = 1'b0;
  logic [BB_W-1:0]    live_bytes  = BB_W'(MIN_BLOCK_BYTES);
  logic [CNT_W-1:0]   live_blocks = '0;
  logic [OFF_W-1:0]   live_offsets [$];

  pool_resp_t         pending_resps [$];
  int                 fail_cnt = 0;

  fixed_block_pool_allocator #(
    .NUM_BLOCKS      (POOL_BLOCKS),
    .MAX_BLOCK_BYTES (POOL_MAX_BYTES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .byte_offset  (byte_offset),
    .done         (done),
    .status       (status),
    .block_offset (block_offset),
    .free_blocks  (free_blocks),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // applies one operation to the free list mirror and returns its response
  function automatic pool_resp_t predict_pool_op(input logic [OP_W-1:0] o,
                                                 input logic [OFF_W-1:0] off);
    pool_resp_t       r;
    logic [OFF_W:0]   span;
    logic [CNT_W-1:0] blk;
    logic [BB_W-1:0]  sz;
    logic [CNT_W-1:0] cnt;
    int unsigned      i;
    logic             hit;
    r = '0;
    r.status = ST_OK;
    case (o)
      OP_ALLOC: begin
        if (!pool_live || top_idx >= LINK_NULL || avail_cnt == 0) begin
          r.status = ST_NO_BLOCK;
        end else begin
          r.offset = OFF_W'(top_idx) * OFF_W'(live_bytes);
          top_idx = link_mem[top_idx[LINK_AW-1:0]];
          avail_cnt = avail_cnt - 1'b1;
          live_offsets.push_back(r.offset);
        end
      end
      OP_FREE: begin
        span = live_bytes * live_blocks;
        if (!pool_live || {1'b0, off} >= span || (off % live_bytes) != 0) begin
          r.status = ST_BAD_OFFSET;
        end else begin
          blk = CNT_W'(off / live_bytes);
          link_mem[blk[LINK_AW-1:0]] = top_idx;
          top_idx = blk;
          if (avail_cnt < live_blocks) avail_cnt = avail_cnt + 1'b1;
          // drop one matching outstanding allocation, if any
          hit = 1'b0;
          for (i = 0; i < live_offsets.size() && !hit; i++) begin
            if (live_offsets[i] == off) begin
              live_offsets.delete(i);
              hit = 1'b1;
            end
          end
        end
      end
      OP_INIT: begin
        sz = cfg_bytes;
        if (sz < MIN_BLOCK_BYTES) sz = BB_W'(MIN_BLOCK_BYTES);
        if (sz > POOL_MAX_BYTES) sz = BB_W'(POOL_MAX_BYTES);
        cnt = cfg_blocks;
        if (cnt > POOL_BLOCKS) cnt = CNT_W'(POOL_BLOCKS);
        live_bytes = sz;
        live_blocks = cnt;
        live_offsets.delete();
        if (cnt == 0) begin
          top_idx = LINK_NULL;
          avail_cnt = '0;
          pool_live = 1'b0;
          r.status = ST_NO_BLOCK;
        end else begin
          for (i = 0; i < cnt; i++)
            link_mem[LINK_AW'(i)] = (i + 1 < cnt) ? CNT_W'(i + 1) : LINK_NULL;
          top_idx = '0;
          avail_cnt = cnt;
          pool_live = 1'b1;
        end
      end
      default: ;
    endcase
    r.free_blocks = avail_cnt;
    return r;
  endfunction

  // drive one item, optionally after a random gap, and record its response
  task automatic send_cmd(input logic [OP_W-1:0] o, input logic [OFF_W-1:0] off,
                          input int idle_pct, input logic typed,
                          input pool_resp_t typed_resp);
    pool_resp_t got;
    // config channel stays quiet while items flow
    cfg_valid <= 1'b0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start       <= 1'b1;
    op          <= o;
    byte_offset <= off;
    do @(posedge clk); while (busy !== 1'b0);
    got = predict_pool_op(o, off);
    pending_resps.push_back(typed ? typed_resp : got);
  endtask

  // register write; valid is left high for a back to back write
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_BLOCK_BYTES) cfg_bytes = val;
    else cfg_blocks = val[CNT_W-1:0];
  endtask

  // stop issuing and wait until every response is in
  task automatic drain_pool();
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_resps.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // response checker
  always @(posedge clk) begin : resp_check
    pool_resp_t want;
    if (!rst && done === 1'b1) begin
      if (pending_resps.size() == 0) begin
        $error("unexpected result: status %0d block_offset 0x%0h free_blocks %0d",
               status, block_offset, free_blocks);
        fail_cnt++;
      end else begin
        want = pending_resps.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_cnt++;
        end
        if (block_offset !== want.offset) begin
          $error("block_offset: expected 0x%0h, got 0x%0h", want.offset, block_offset);
          fail_cnt++;
        end
        if (free_blocks !== want.free_blocks) begin
          $error("free_blocks: expected %0d, got %0d", want.free_blocks, free_blocks);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no item taken and no result
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus
  initial begin : stim
    int               ph;
    int               n;
    int               pick;
    int               pct;
    logic [OP_W-1:0]  cmd_op;
    logic [OFF_W-1:0] cmd_off;
    logic [BB_W-1:0]  size_pick;
    logic [CFG_W-1:0] cnt_pick;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (PLAN[r]) begin
      if (PLAN[r].is_cfg) begin
        drain_pool();
        write_reg(PLAN[r].cfg_idx, PLAN[r].data[CFG_W-1:0]);
      end else begin
        send_cmd(PLAN[r].op, PLAN[r].data, 0, PLAN[r].typed, PLAN[r].resp);
      end
    end

    // random phases, each under its own register setting and idle rate
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 6) begin
        size_pick = PHASE_BYTES[ph];
        cnt_pick  = PHASE_COUNTS[ph];
      end else begin
        case ($urandom_range(0, 7))
          0:       size_pick = BB_W'($urandom_range(0, 7));
          1:       size_pick = BB_W'(MIN_BLOCK_BYTES);
          2:       size_pick = BB_W'(POOL_MAX_BYTES);
          3:       size_pick = BB_W'($urandom_range(POOL_MAX_BYTES + 1, 8191));
          default: size_pick = BB_W'($urandom_range(9, POOL_MAX_BYTES - 1));
        endcase
        case ($urandom_range(0, 7))
          0:       cnt_pick = '0;
          1:       cnt_pick = CFG_W'(1);
          2:       cnt_pick = CFG_W'(2);
          3:       cnt_pick = CFG_W'(POOL_BLOCKS);
          4:       cnt_pick = CFG_W'($urandom_range(POOL_BLOCKS + 1, 511));
          default: cnt_pick = CFG_W'($urandom_range(3, POOL_BLOCKS - 1));
        endcase
        // upper data bits are outside the count register
        cnt_pick[CFG_W-1:CNT_W] = (CFG_W - CNT_W)'($urandom);
      end
      pct = PHASE_IDLE[ph % 3];
      drain_pool();
      write_reg(REG_BLOCK_BYTES, size_pick);
      write_reg(REG_BLOCKS_IN_USE, cnt_pick);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick    = $urandom_range(0, 99);
        cmd_off = OFF_W'($urandom);
        cmd_op  = OP_FREE;
        if (n == 0 || pick < 3 || (!pool_live && pick < 50)) begin
          cmd_op = OP_INIT;
        end else if (pick < 45) begin
          cmd_op = OP_ALLOC;
        end else if (pick < 80) begin
          // well-formed free of a block handed out earlier
          if (live_offsets.size() != 0)
            cmd_off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
        end else if (pick < 86) begin
          // free of a raw offset, kept as drawn
        end else if (pick < 91) begin
          // misaligned offset inside the pool or in the block just past its end
          cmd_off = OFF_W'(live_bytes * $urandom_range(0, live_blocks) +
                           $urandom_range(1, live_bytes - 1));
        end else if (pick < 95) begin
          // at or just past the end of the pool
          cmd_off = OFF_W'(live_bytes * live_blocks +
                           $urandom_range(0, 3 * live_bytes));
        end else if (pick < 98) begin
          // aligned offset up to the pool end; the block may already be free
          cmd_off = OFF_W'(live_bytes * $urandom_range(0, live_blocks));
        end else begin
          cmd_op = OP_UNUSED;
        end
        send_cmd(cmd_op, cmd_off, pct, 1'b0, '0);
      end
    end

    drain_pool();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== fixed_block_pool_allocator.f =====
rtl/core/fpa_pkg.sv
rtl/core/fpa_ctrl.sv
rtl/core/fpa_dpath.sv
rtl/core/fixed_block_pool_allocator.sv
verif/tb_top.sv
